/* sv/crc16_generate_and_check_macros.svh */
// Assertion macros shared by the CRC-16 generator and checker RTL
`ifndef CRC16_GENERATE_AND_CHECK_MACROS_SVH
`define CRC16_GENERATE_AND_CHECK_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define CRC16_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define CRC16_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/crc16_pkg.sv */
// Shared types, constants and the bit-step function of the CRC-16 block
`default_nettype none
package crc16_pkg;

  localparam int unsigned CRC_W = 16;

  typedef logic [CRC_W-1:0] crc_t;

  // Generator coefficients after reset (x^12 + x^5 + 1, x^16 implied)
  localparam crc_t POLY_RESET = 16'h1021;
  localparam crc_t CRC_ZERO   = '0;

  // One input request as held in the input register
  typedef struct packed {
    logic msg_bit;
    logic last_bit;
    logic check_frame;
  } in_item_t;

  // One long-division step over GF(2), MSB first
  function automatic crc_t crc_advance(crc_t rem, logic din, logic check, crc_t poly);
    logic top;
    crc_t shifted;
    crc_t result;
    top = rem[CRC_W-1];
    if (check) begin
      // frame bit enters at the bottom; subtract G when x^16 appears
      shifted = {rem[CRC_W-2:0], din};
      result  = top ? (shifted ^ poly) : shifted;
    end else begin
      // message * x^16 divided directly
      shifted = {rem[CRC_W-2:0], 1'b0};
      result  = (top ^ din) ? (shifted ^ poly) : shifted;
    end
    return result;
  endfunction

endpackage
`default_nettype wire

/* sv/crc16_ifs.sv */
// Valid/ready channel interfaces of the CRC-16 block
`default_nettype none

// Input bit channel
interface crc16_in_if;
  logic valid;
  logic ready;
  logic msg_bit;
  logic last_bit;
  logic check_frame;
  modport source (output valid, output msg_bit, output last_bit, output check_frame,
                  input ready);
  modport sink (input valid, input msg_bit, input last_bit, input check_frame,
                output ready);
endinterface

// Result channel
interface crc16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] crc_value;
  logic        frame_error;
  modport source (output valid, output crc_value, output frame_error, input ready);
  modport sink (input valid, input crc_value, input frame_error, output ready);
endinterface

// Generator register write channel
interface crc16_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] generator_poly;
  modport source (output valid, output generator_poly, input ready);
  modport sink (input valid, input generator_poly, output ready);
endinterface

`default_nettype wire

/* sv/crc16_ingress.sv */
// Input register: holds one bit request until the division stage takes it
`default_nettype none
module crc16_ingress (
  input  wire logic              clk,
  input  wire logic              rst_n,
  crc16_in_if.sink               in_ch,
  input  wire logic              take,
  output logic                   item_valid,
  output crc16_pkg::in_item_t    item
);
  import crc16_pkg::*;

  logic     item_valid_r;
  logic     item_valid_nxt;
  in_item_t item_r;
  logic     accept;

  // Free when empty or when the held request leaves this cycle
  assign in_ch.ready = !item_valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  assign item_valid_nxt = accept || (item_valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{msg_bit: in_ch.msg_bit, last_bit: in_ch.last_bit,
                  check_frame: in_ch.check_frame};
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

/* sv/crc16_div_stage.sv */
// Division stage: remainder register, generator register and result register
`default_nettype none
`include "crc16_generate_and_check_macros.svh"
module crc16_div_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire crc16_pkg::in_item_t item,
  output logic                   take,
  crc16_cfg_if.sink              cfg_ch,
  crc16_out_if.source            out_ch
);
  import crc16_pkg::*;

  crc_t poly_r;
  crc_t rem_r;
  crc_t rem_nxt;
  crc_t step;
  logic out_valid_r;
  logic out_valid_nxt;
  crc_t crc_r;
  logic err_r;
  logic slot_free;

  // Generator register, always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r <= POLY_RESET;
    end else if (cfg_ch.valid) begin
      poly_r <= cfg_ch.generator_poly;
    end
  end

  // A last bit needs the result slot; other bits always pass
  assign slot_free = !out_valid_r || out_ch.ready;
  assign take      = item_valid && (!item.last_bit || slot_free);

  // One shift and conditional subtract per bit
  assign step    = crc_advance(rem_r, item.msg_bit, item.check_frame, poly_r);
  assign rem_nxt = !take ? rem_r : (item.last_bit ? CRC_ZERO : step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= CRC_ZERO;
    end else begin
      rem_r <= rem_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take && item.last_bit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.last_bit) begin
      crc_r <= step;
      err_r <= item.check_frame && (step != CRC_ZERO);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.crc_value   = crc_r;
  assign out_ch.frame_error = err_r;

  // Checks
  `CRC16_ASSERT_NEXT(a_clear_after_last, take && item.last_bit, rem_r == CRC_ZERO,
    "remainder not cleared after last bit")
  `CRC16_ASSERT_SAME(a_err_nonzero, out_valid_r && err_r, crc_r != CRC_ZERO,
    "frame error with zero remainder")
  `CRC16_ASSERT_NEXT(a_no_spurious_out,
    !(take && item.last_bit) && (!out_valid_r || out_ch.ready), !out_valid_r,
    "result produced without a last bit")
  `CRC16_ASSERT_SAME(a_last_waits, item_valid && item.last_bit && !slot_free, !take,
    "last bit taken while result slot is full")

endmodule
`default_nettype wire

/* sv/crc16_generate_and_check.sv */
// Top level of the bit-serial CRC-16 generator and checker
//
// Channels: in_ch carries one bit request (msg_bit, last_bit, check_frame),
// MSB first; out_ch carries one result (crc_value, frame_error) per frame,
// given on the request marked last_bit; cfg_ch writes generator_poly, the
// low sixteen coefficients of the generator (x^16 implied). Every channel
// moves a request when valid and ready are both high.
// Path: a last bit accepted on in_ch reaches out_ch through two register
// stages (input register, result register).
// Throughput: one bit per cycle unless a last bit waits on a held result;
// the two registers are separate, so bits keep flowing while a result waits.
// Stall: while out_ch.ready is low and a result is held, non-last bits
// still pass; a following last bit waits in the input register and in_ch
// then drops ready until the result is taken.
// Reset (rst_n low, synchronous): remainder cleared, generator set to
// 0x1021, no request held or pending. No clearing pass is needed.
`default_nettype none
module crc16_generate_and_check (
  input  wire logic   clk,
  input  wire logic   rst_n,
  crc16_in_if.sink    in_ch,
  crc16_cfg_if.sink   cfg_ch,
  crc16_out_if.source out_ch
);
  import crc16_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     take;

  // Input register
  crc16_ingress u_ingress (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Division and result stage
  crc16_div_stage u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .cfg_ch     (cfg_ch),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
